/* design/sswq_pkg.sv */
// ----------------------------------------------------------------------------
// sswq_pkg : shared types and constants for the sorted sleep/wakeup queue
// Result kinds, default sizes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sswq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;

  localparam int TICK_W = 63;
  localparam int DUR_W  = 32;
  localparam int OID_W  = 8;
  localparam int KIND_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input item
    logic prep_tick;   // bump tick counter, read head
    logic prep_sleep;  // compute wake time, open hole at tail
    logic reject;      // report queue full
    logic shift;       // one insertion step
    logic place;       // write new entry into hole
    logic pop;         // one wakeup step
  } sswq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_tick;
    logic full;
    logic empty;
    logic shift_go;    // entry before hole wakes later than new entry
    logic cnt_one;     // one entry left to compare
    logic pop_go;      // head entry is due
  } sswq_stat_t;

endpackage

/* design/sswq_ctrl.sv */
// ----------------------------------------------------------------------------
// sswq_ctrl : sequencer for the sorted sleep/wakeup queue
// One-hot state machine that steps inserts and wakeup bursts.
// ----------------------------------------------------------------------------
module sswq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sswq_pkg::sswq_stat_t stat,
  output sswq_pkg::sswq_cmd_t  cmd
);
  import sswq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_PLACE = 5'b01000,
    ST_POP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.op_tick) begin
          cmd.prep_tick = 1'b1;
          state_nxt     = ST_POP;
        end else if (stat.full) begin
          cmd.reject = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.prep_sleep = 1'b1;
          state_nxt      = stat.empty ? ST_PLACE : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (!stat.shift_go || stat.cnt_one) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_POP: begin
        cmd.pop = 1'b1;
        if (!stat.pop_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/sswq_dpath.sv */
// ----------------------------------------------------------------------------
// sswq_dpath : datapath for the sorted sleep/wakeup queue
// Tick counter, circular entry store, insertion and wakeup steps, result regs.
// ----------------------------------------------------------------------------
module sswq_dpath #(
  parameter int QUEUE_DEPTH = sswq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = sswq_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_op,
  input  logic [sswq_pkg::OID_W-1:0]  in_sleeper_id,
  input  logic [sswq_pkg::DUR_W-1:0]  in_duration,
  input  sswq_pkg::sswq_cmd_t         cmd,
  output sswq_pkg::sswq_stat_t        stat,
  output logic                        out_valid,
  output logic [sswq_pkg::KIND_W-1:0] out_kind,
  output logic [sswq_pkg::OID_W-1:0]  out_woken_id,
  output logic                        out_last
);
  import sswq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [OID_W-1:0] id_out(input logic [ID_WIDTH-1:0] id);
    logic [15:0] w;
    w = 16'(id);
    return w[OID_W-1:0];
  endfunction

  function automatic logic [ID_WIDTH-1:0] id_in(input logic [OID_W-1:0] id);
    logic [15:0] w;
    w = 16'(id);
    return w[ID_WIDTH-1:0];
  endfunction

  // entry store
  logic [TICK_W-1:0]   mem_time [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] mem_id   [QUEUE_DEPTH];

  logic                op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [DUR_W-1:0]    dur_r;
  logic [TICK_W-1:0]   wake_r, wake_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [PW-1:0]       tail_r, tail_nxt;
  logic [PW-1:0]       hole_r, hole_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [OW-1:0]       cnt_r, cnt_nxt;
  logic [TICK_W-1:0]   rd_time_r;
  logic [ID_WIDTH-1:0] rd_id_r;
  logic                pend_r, pend_nxt;
  logic [ID_WIDTH-1:0] pend_id_r, pend_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [OID_W-1:0]    out_id_r, out_id_nxt;
  logic                out_last_r, out_last_nxt;

  logic [PW-1:0]       rd_addr;
  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic [TICK_W-1:0]   wr_time;
  logic [ID_WIDTH-1:0] wr_id;
  logic [TICK_W:0]     wake_sum;

  // wake time, saturating at the counter maximum
  assign wake_sum = {1'b0, tick_r} + (TICK_W + 1)'(dur_r);

  assign stat.op_tick  = op_r;
  assign stat.full     = (occ_r == OW'(QUEUE_DEPTH));
  assign stat.empty    = (occ_r == '0);
  assign stat.shift_go = (rd_time_r > wake_r);
  assign stat.cnt_one  = (cnt_r == OW'(1));
  assign stat.pop_go   = (occ_r != '0) && (rd_time_r <= tick_r);

  always_comb begin
    wake_nxt      = wake_r;
    tick_nxt      = tick_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    hole_nxt      = hole_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = hole_r;
    wr_time       = rd_time_r;
    wr_id         = rd_id_r;

    if (cmd.prep_tick) begin
      if (tick_r != TICK_MAX) begin
        tick_nxt = tick_r + 1'b1;
      end
      pend_nxt = 1'b0;
      rd_addr  = head_r;
    end

    if (cmd.reject) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_REJECT;
      out_id_nxt    = id_out(id_r);
      out_last_nxt  = 1'b1;
    end

    if (cmd.prep_sleep) begin
      wake_nxt = wake_sum[TICK_W] ? TICK_MAX : wake_sum[TICK_W-1:0];
      hole_nxt = tail_r;
      cnt_nxt  = occ_r;
      rd_addr  = ptr_dec(tail_r);
    end

    // move the entry before the hole up by one and read the next one down
    if (cmd.shift && stat.shift_go) begin
      wr_en    = 1'b1;
      wr_addr  = hole_r;
      hole_nxt = ptr_dec(hole_r);
      cnt_nxt  = cnt_r - 1'b1;
      rd_addr  = ptr_dec(ptr_dec(hole_r));
    end

    if (cmd.place) begin
      wr_en         = 1'b1;
      wr_addr       = hole_r;
      wr_time       = wake_r;
      wr_id         = id_r;
      tail_nxt      = ptr_inc(tail_r);
      occ_nxt       = occ_r + 1'b1;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_ACCEPT;
      out_id_nxt    = id_out(id_r);
      out_last_nxt  = 1'b1;
    end

    // one woken sleeper is held back a step so that last is known
    if (cmd.pop) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_WOKEN;
        out_id_nxt    = id_out(pend_id_r);
        out_last_nxt  = !stat.pop_go;
      end else if (!stat.pop_go) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_NONE;
        out_id_nxt    = '0;
        out_last_nxt  = 1'b1;
      end
      if (stat.pop_go) begin
        pend_nxt    = 1'b1;
        pend_id_nxt = rd_id_r;
        head_nxt    = ptr_inc(head_r);
        occ_nxt     = occ_r - 1'b1;
        rd_addr     = ptr_inc(head_r);
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wr_addr] <= wr_time;
      mem_id[wr_addr]   <= wr_id;
    end
    rd_time_r <= mem_time[rd_addr];
    rd_id_r   <= mem_id[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      id_r  <= id_in(in_sleeper_id);
      dur_r <= in_duration;
    end
    wake_r       <= wake_nxt;
    hole_r       <= hole_nxt;
    cnt_r        <= cnt_nxt;
    pend_id_r    <= pend_id_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_woken_id = out_id_r;
  assign out_last     = out_last_r;

endmodule

/* design/sorted_sleep_wakeup_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_sleep_wakeup_queue_unit : timer wakeup priority queue
// Tick counter plus a wake-time ordered queue of sleepers, one item at a time.
// ----------------------------------------------------------------------------
// Sleep item: busy through prepare, the insertion walk and the write (one
//   compare-and-move per cycle); a full queue rejects it at prepare.
// Tick item: busy through prepare and the wakeup walk, one result per cycle.
// The final result shows in the first cycle with busy low; the next item may
//   start then. Results are strobes on out_valid and cannot be held off.
// Synchronous active-low reset empties the queue and clears the counter.
// ----------------------------------------------------------------------------
module sorted_sleep_wakeup_queue_unit #(
  parameter int QUEUE_DEPTH = sswq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = sswq_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [sswq_pkg::OID_W-1:0]  in_sleeper_id,
  input  logic [sswq_pkg::DUR_W-1:0]  in_duration,
  // result side
  output logic                        out_valid,
  output logic [sswq_pkg::KIND_W-1:0] out_kind,
  output logic [sswq_pkg::OID_W-1:0]  out_woken_id,
  output logic                        out_last
);
  import sswq_pkg::*;

  // Controller steps the item: capture, prepare, then either the insertion
  // walk (from the tail towards the head, one compare-and-move per cycle) or
  // the wakeup walk (from the head, one due entry popped per cycle).
  sswq_cmd_t  cmd;
  sswq_stat_t stat;

  sswq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath holds the counter, the circular entry store (head/tail pointers,
  // registered read port) and the result registers.
  sswq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_sleeper_id (in_sleeper_id),
    .in_duration   (in_duration),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_woken_id  (out_woken_id),
    .out_last      (out_last)
  );

endmodule

/* test/tb_sorted_sleep_wakeup_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_sorted_sleep_wakeup_queue_unit : self-checking bench for the wakeup queue
// Drives sleep and tick items through the command port and predicts every
// result from a local model of the counter and queue. Each strobed result is
// compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_sorted_sleep_wakeup_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sswq_pkg::*;

  // item opcodes
  localparam logic OP_SLEEP = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 150000;
  localparam int RAND_ITEMS  = 280;
  localparam int CALM_TAIL   = 60;   // final random items sent with no pauses
  localparam int LONG_ITEMS  = 20;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OID_W-1:0]  id;
    logic              last;
  } wake_report_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_op;
  logic [OID_W-1:0]  in_sleeper_id;
  logic [DUR_W-1:0]  in_duration;
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [OID_W-1:0]  out_woken_id;
  logic              out_last;

  // local copy of the block's state
  logic [TICK_W-1:0] tick_now;
  logic [TICK_W-1:0] wake_at_q[$];   // sorted, earliest first
  logic [OID_W-1:0]  sleeper_q[$];   // ids, same order as wake_at_q

  wake_report_t pending_reports[$];  // predicted results not yet seen

  int  error_count;
  int  cycle_count;
  bit  pauses_on;

  sorted_sleep_wakeup_queue_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_sleeper_id (in_sleeper_id),
    .in_duration   (in_duration),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_woken_id  (out_woken_id),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far above the slowest legal run (every item fully busy plus
  // the longest pause).
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Sleep: one result. Full queue rejects and leaves state alone. Wake time
  // saturates at the counter max; entry lands after all equal wake times.
  function automatic void predict_sleep(logic [OID_W-1:0] id, logic [DUR_W-1:0] dur);
    logic [TICK_W:0]   sum;
    logic [TICK_W-1:0] wake;
    int                pos;
    if (wake_at_q.size() >= DEPTH) begin
      pending_reports.push_back('{kind: KIND_REJECT, id: id, last: 1'b1});
      return;
    end
    sum  = {1'b0, tick_now} + {{(TICK_W + 1 - DUR_W){1'b0}}, dur};
    wake = (sum > {1'b0, TICK_MAX}) ? TICK_MAX : sum[TICK_W-1:0];
    pos  = 0;
    while (pos < wake_at_q.size() && wake_at_q[pos] <= wake)
      pos++;
    wake_at_q.insert(pos, wake);
    sleeper_q.insert(pos, id);
    pending_reports.push_back('{kind: KIND_ACCEPT, id: id, last: 1'b1});
  endfunction

  // Tick: bump the saturating counter, then pop every due entry at the head.
  function automatic void predict_tick();
    int due;
    if (tick_now != TICK_MAX)
      tick_now++;
    due = 0;
    while (due < wake_at_q.size() && wake_at_q[due] <= tick_now)
      due++;
    if (due == 0) begin
      pending_reports.push_back('{kind: KIND_NONE, id: '0, last: 1'b1});
      return;
    end
    for (int i = 0; i < due; i++) begin
      pending_reports.push_back('{kind: KIND_WOKEN, id: sleeper_q[0],
                                  last: (i == due - 1)});
      void'(wake_at_q.pop_front());
      void'(sleeper_q.pop_front());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: results are strobes, taken at the edge ending their cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    wake_report_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kind %0d id %0d last %0d",
                   out_kind, out_woken_id, out_last);
      end else begin
        want = pending_reports.pop_front();
        if (out_kind !== want.kind || out_woken_id !== want.id ||
            out_last !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                     want.kind, want.id, want.last, out_kind, out_woken_id, out_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Start stays high until an edge sees busy low; that edge takes the item.
  // Holding start across items gives back-to-back issue with no pause.
  task automatic send_item(logic op, logic [OID_W-1:0] id, logic [DUR_W-1:0] dur);
    @(negedge clk);
    in_op         = op;
    in_sleeper_id = id;
    in_duration   = dur;
    start         = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_SLEEP)
      predict_sleep(id, dur);
    else
      predict_tick();
  endtask

  // Random burst of dead cycles before the next item, when pauses are on.
  task automatic maybe_pause();
    int n;
    if (!pauses_on || $urandom_range(0, 3) != 0)
      return;
    n = $urandom_range(1, 18);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Tick with nothing queued: single no-wake result.
  task automatic test_tick_on_empty();
    send_item(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Equal wake times leave in arrival order; zero duration wakes next tick.
  task automatic test_equal_wake_order();
    send_item(OP_SLEEP, 8'h00, 32'd1);
    send_item(OP_SLEEP, 8'hFF, 32'd1);
    send_item(OP_SLEEP, 8'h5A, 32'd0);
    send_item(OP_TICK, 8'h00, 32'd0);
    wait_drained();
  endtask

  // Fill to depth, one rejected sleep, then one tick wakes all sixteen,
  // and a further tick wakes nobody.
  task automatic test_full_queue_burst();
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_SLEEP, OID_W'($urandom), DUR_W'($urandom_range(0, 1)));
    send_item(OP_SLEEP, 8'hA5, 32'd0);
    send_item(OP_TICK, 8'h00, 32'd0);
    send_item(OP_TICK, 8'h00, 32'd0);
    wait_drained();
  endtask

  // Mixed traffic with short sleeps so wakeups are frequent. Occasional
  // bursts of sleeps push the queue to full and give multi-wake ticks.
  task automatic test_random_traffic();
    int sent;
    int burst;
    sent  = 0;
    burst = 0;
    while (sent < RAND_ITEMS) begin
      if (sent % 20 == 0)
        pauses_on = ($urandom_range(0, 2) != 0);
      if (sent >= RAND_ITEMS - CALM_TAIL)
        pauses_on = 1'b0;
      if (sent == RAND_ITEMS / 2)
        wait_drained();
      maybe_pause();
      if (burst == 0 && $urandom_range(0, 19) == 0)
        burst = $urandom_range(4, 12);
      if (burst > 0) begin
        burst--;
        send_item(OP_SLEEP, OID_W'($urandom), DUR_W'($urandom_range(0, 3)));
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(OP_SLEEP, OID_W'($urandom),
                  ($urandom_range(0, 3) == 0) ? DUR_W'($urandom_range(9, 40))
                                              : DUR_W'($urandom_range(0, 8)));
      end else begin
        // fields are don't-care on a tick; drive noise
        send_item(OP_TICK, OID_W'($urandom), DUR_W'($urandom));
      end
      sent++;
    end
    wait_drained();
  endtask

  // Full-range durations, including all ones. These sleepers never wake in
  // this run, so this goes last; it usually ends with rejects on a full queue.
  // Sent back to back: the end of the run has no idle gaps.
  task automatic test_long_sleepers();
    for (int k = 0; k < LONG_ITEMS; k++) begin
      if (k == 0)
        send_item(OP_SLEEP, OID_W'($urandom), 32'hFFFF_FFFF);
      else if ($urandom_range(0, 4) == 0)
        send_item(OP_TICK, OID_W'($urandom), DUR_W'($urandom));
      else
        send_item(OP_SLEEP, OID_W'($urandom), DUR_W'($urandom));
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_op         = OP_SLEEP;
    in_sleeper_id = '0;
    in_duration   = '0;
    error_count   = 0;
    cycle_count   = 0;
    pauses_on     = 1'b0;
    tick_now      = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_tick_on_empty();
    test_equal_wake_order();
    test_full_queue_burst();
    test_random_traffic();
    test_long_sleepers();

    // tail: nothing more should appear; anything still pending is lost
    repeat (40) @(posedge clk);
    if (pending_reports.size() != 0)
      error_count++;

    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
